// ----- sv/flrs_pkg.sv -----
package flrs_pkg;

   localparam int HEADER_BYTES_DEF    = 16;
   localparam int MAX_BLOCK_BYTES_DEF = 65536;

   localparam int OFS_W  = 17;
   localparam int CNT_W  = 15;
   localparam int ITEM_W = 8;
   localparam int BIR_W  = 9;

   localparam logic [ITEM_W-1:0] ITEM_RESET = 8'd16;
   localparam logic [7:0]        FLAG_VALID = 8'h7C;
   localparam logic [7:0]        ERASED     = 8'hFF;
   localparam logic [CNT_W-1:0]  CNT_MAX    = 15'h7FFF;
   localparam logic [OFS_W-1:0]  OFS_MAX    = 17'h1FFFF;

   typedef enum logic [1:0] {
      CLASS_BLANK   = 2'd0,
      CLASS_VALID   = 2'd1,
      CLASS_INVALID = 2'd2
   } record_class_type;

   typedef enum logic {
      CSR_ITEM_SIZE  = 1'b0,
      CSR_BLOCK_SIZE = 1'b1
   } csr_index_type;

   // settings seen by the scan logic
   typedef struct packed {
      logic [ITEM_W-1:0] item_size;
      logic [OFS_W-1:0]  block_even;
      logic              rebase;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]  record_index;
      record_class_type  record_class;
      logic [CNT_W-1:0]  valid_count;
      logic [CNT_W:0]    end_index;
      logic              scan_done;
      logic              block_full;
   } result_type;

endpackage

// ----- sv/flrs_if.sv -----
interface flrs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface flrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] record_index;
   logic [1:0]  record_class;
   logic [14:0] valid_count;
   logic [15:0] end_index;
   logic        scan_done;
   logic        block_full;

   modport source (output valid, output record_index, output record_class,
                   output valid_count, output end_index, output scan_done,
                   output block_full, input ready);
   modport sink   (input valid, input record_index, input record_class,
                   input valid_count, input end_index, input scan_done,
                   input block_full, output ready);
endinterface

// ----- sv/flrs_csr.sv -----
module flrs_csr #(
   parameter int MAX_BLOCK_BYTES = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  flrs_pkg::csr_index_type csr_index,
   input  logic [16:0]             csr_write_data,
   output flrs_pkg::cfg_type       cfg
);
   import flrs_pkg::*;

   logic [ITEM_W-1:0] item_ff, item_in;
   logic [OFS_W-1:0]  bs_ff, bs_in;
   logic              rebase_ff, rebase_in;
   logic [OFS_W:0]    rounded;

   // round up to even, then cap at the largest block
   assign rounded = ({1'b0, csr_write_data} + 18'd1) & ~18'd1;

   always_comb begin
      item_in   = item_ff;
      bs_in     = bs_ff;
      rebase_in = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ITEM_SIZE: begin
               item_in   = csr_write_data[ITEM_W-1:0];
               rebase_in = 1'b1;
            end
            CSR_BLOCK_SIZE: begin
               if (rounded > (OFS_W+1)'(MAX_BLOCK_BYTES))
                  bs_in = OFS_W'(MAX_BLOCK_BYTES);
               else
                  bs_in = rounded[OFS_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff   <= ITEM_RESET;
         bs_ff     <= OFS_W'(MAX_BLOCK_BYTES);
         rebase_ff <= 1'b0;
      end else begin
         item_ff   <= item_in;
         bs_ff     <= bs_in;
         rebase_ff <= rebase_in;
      end
   end

   assign cfg.item_size  = item_ff;
   assign cfg.block_even = bs_ff;
   assign cfg.rebase     = rebase_ff;

endmodule

// ----- sv/flrs_scan.sv -----
module flrs_scan #(
   parameter int HEADER_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  flrs_pkg::cfg_type    cfg,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 restart,
   output logic                 res_valid,
   output flrs_pkg::result_type result
);
   import flrs_pkg::*;

   logic [BIR_W-1:0]  bir_ff, bir_in, bir_e;
   logic [7:0]        psum_ff, psum_in, psum_e;
   logic              ones_ff, ones_in, ones_e;
   logic [7:0]        ssum_ff, ssum_in, ssum_e;
   logic [CNT_W-1:0]  rec_ff, rec_in, rec_e;
   logic [CNT_W-1:0]  vtot_ff, vtot_in, vtot_e;
   logic [OFS_W-1:0]  nof_ff, nof_in, nof_e;
   logic              fin_ff, fin_in, fin_e;

   logic [BIR_W-1:0]  rec_len;
   logic [BIR_W-1:0]  item_ext;
   logic [CNT_W:0]    rec_plus1;
   logic [24:0]       rebase_prod;
   logic [25:0]       rebase_sum;
   logic [OFS_W-1:0]  rebase_ofs;
   logic [OFS_W-1:0]  nof_cur;
   logic [OFS_W:0]    nof_add;
   logic [OFS_W:0]    full_lhs;
   logic [CNT_W:0]    end_idx;
   logic              flag_ff_code, flag_ok;
   logic              full;
   record_class_type  cls;

   assign item_ext  = {1'b0, cfg.item_size};
   assign rec_len   = item_ext + 9'd2;
   assign rec_plus1 = {1'b0, rec_ff} + 16'd1;

   // position after a record-length change
   assign rebase_prod = {9'b0, rec_plus1} * {16'b0, rec_len};
   assign rebase_sum  = {1'b0, rebase_prod} + 26'(HEADER_BYTES);
   assign rebase_ofs  = (rebase_sum > 26'(OFS_MAX)) ? OFS_MAX : rebase_sum[OFS_W-1:0];

   // a pending length change takes effect ahead of the word
   assign nof_cur = cfg.rebase ? rebase_ofs : nof_ff;

   // restart clears the scan before this word is taken
   always_comb begin
      if (restart) begin
         bir_e  = '0;
         psum_e = '0;
         ones_e = 1'b1;
         ssum_e = '0;
         rec_e  = '0;
         vtot_e = '0;
         fin_e  = 1'b0;
         nof_e  = OFS_W'(HEADER_BYTES) + {8'b0, rec_len};
      end else begin
         bir_e  = bir_ff;
         psum_e = psum_ff;
         ones_e = ones_ff;
         ssum_e = ssum_ff;
         rec_e  = rec_ff;
         vtot_e = vtot_ff;
         fin_e  = fin_ff;
         nof_e  = nof_cur;
      end
   end

   assign flag_ff_code = (data_byte == ERASED);
   assign flag_ok      = flag_ff_code || (data_byte == FLAG_VALID);

   always_comb begin
      if (!flag_ok)
         cls = CLASS_INVALID;
      else if (psum_e == ssum_e) begin
         if (!flag_ff_code)
            cls = CLASS_VALID;
         else
            cls = ones_e ? CLASS_BLANK : CLASS_INVALID;
      end else if (ssum_e == ERASED && flag_ff_code)
         cls = ones_e ? CLASS_BLANK : CLASS_INVALID;
      else
         cls = CLASS_INVALID;
   end

   assign nof_add  = {1'b0, nof_e} + {9'b0, rec_len};
   assign full_lhs = {1'b0, nof_e} + {9'b0, cfg.item_size, 1'b0};

   always_comb begin
      bir_in    = bir_e;
      psum_in   = psum_e;
      ones_in   = ones_e;
      ssum_in   = ssum_e;
      rec_in    = rec_e;
      vtot_in   = vtot_e;
      nof_in    = nof_e;
      fin_in    = fin_e;
      full      = 1'b0;
      res_valid = 1'b0;
      end_idx   = {1'b0, rec_e};
      if (!fin_e) begin
         if (bir_e < item_ext) begin
            psum_in = psum_e + data_byte;
            if (!flag_ff_code)
               ones_in = 1'b0;
            bir_in = bir_e + 9'd1;
         end else if (bir_e == item_ext) begin
            ssum_in = data_byte;
            bir_in  = bir_e + 9'd1;
         end else begin
            res_valid = 1'b1;
            if (cls == CLASS_BLANK) begin
               fin_in = 1'b1;
            end else begin
               if (cls == CLASS_VALID && vtot_e != CNT_MAX)
                  vtot_in = vtot_e + 15'd1;
               // next record would not leave room for two more
               if (full_lhs > {1'b0, cfg.block_even}) begin
                  full   = 1'b1;
                  fin_in = 1'b1;
               end
               end_idx = {1'b0, rec_e} + 16'd1;
               nof_in = nof_add[OFS_W] ? OFS_MAX : nof_add[OFS_W-1:0];
               if (rec_e != CNT_MAX)
                  rec_in = rec_e + 15'd1;
            end
            bir_in  = '0;
            psum_in = '0;
            ones_in = 1'b1;
            ssum_in = '0;
         end
      end
   end

   assign result.record_index = rec_e;
   assign result.record_class = cls;
   assign result.valid_count  = vtot_in;
   assign result.end_index    = end_idx;
   assign result.scan_done    = fin_in;
   assign result.block_full   = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         bir_ff  <= '0;
         psum_ff <= '0;
         ones_ff <= 1'b1;
         ssum_ff <= '0;
         rec_ff  <= '0;
         vtot_ff <= '0;
         nof_ff  <= OFS_W'(HEADER_BYTES) + {8'b0, ITEM_RESET, 1'b0} - OFS_W'(ITEM_RESET)
                    + 17'd2;
         fin_ff  <= 1'b0;
      end else if (step) begin
         bir_ff  <= bir_in;
         psum_ff <= psum_in;
         ones_ff <= ones_in;
         ssum_ff <= ssum_in;
         rec_ff  <= rec_in;
         vtot_ff <= vtot_in;
         nof_ff  <= nof_in;
         fin_ff  <= fin_in;
      end else if (cfg.rebase) begin
         nof_ff <= rebase_ofs;
      end
   end

   a_no_word_after_done: assert property (@(posedge clock) disable iff (reset)
      step && fin_ff && !restart |-> !res_valid)
      else $error("record reported after scan finished");

   a_offset_grows: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && cls != CLASS_BLANK && !cfg.rebase |=>
      nof_ff > $past(nof_e) || nof_ff == OFS_MAX)
      else $error("record offset did not advance");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      step && !cfg.rebase |=> bir_ff <= {1'b0, cfg.item_size} + 9'd1)
      else $error("byte position beyond record");

endmodule

// ----- sv/flash_log_record_scanner_unit.sv -----
// Path: a word accepted into the input register is classified from that register, and
// when the output is free its result is registered on rsp.
// Throughput: one byte per cycle; input register and result register decouple the
// channels, so only a stalled result holds the input.
// Reset (synchronous): item_size 16, block_size 65536, scan state cleared.
module flash_log_record_scanner_unit #(
   parameter int HEADER_BYTES    = flrs_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCK_BYTES = flrs_pkg::MAX_BLOCK_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   flrs_req_if.sink                req_chan,
   flrs_rsp_if.source              rsp_chan,
   input  logic                    csr_write_enable,
   input  flrs_pkg::csr_index_type csr_index,
   input  logic [16:0]             csr_write_data
);
   import flrs_pkg::*;

   cfg_type     cfg;
   result_type  result;
   logic        res_valid;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_restart_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   logic        out_free, step, take;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign step     = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign take     = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = take || (s1_valid_ff && !step);
   assign rsp_valid_in = out_free ? (step && res_valid) : rsp_valid_ff;

   flrs_csr #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   flrs_scan #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .data_byte (s1_byte_ff),
      .restart   (s1_restart_ff),
      .res_valid (res_valid),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: input loads on acceptance, result on a reported record; hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         s1_byte_ff    <= req_chan.data_byte;
         s1_restart_ff <= req_chan.restart;
      end
      if (step && res_valid)
         rsp_ff <= result;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.record_index = rsp_ff.record_index;
   assign rsp_chan.record_class = rsp_ff.record_class;
   assign rsp_chan.valid_count  = rsp_ff.valid_count;
   assign rsp_chan.end_index    = rsp_ff.end_index;
   assign rsp_chan.scan_done    = rsp_ff.scan_done;
   assign rsp_chan.block_full   = rsp_ff.block_full;

   a_blank_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.record_class == CLASS_BLANK |->
      rsp_ff.scan_done && !rsp_ff.block_full)
      else $error("blank record without clean finish");

   a_full_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.block_full |-> rsp_ff.scan_done)
      else $error("block full without finish");

   a_end_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.end_index == {1'b0, rsp_ff.record_index}
         + ((rsp_ff.record_class == CLASS_BLANK) ? 16'd0 : 16'd1))
      else $error("end index inconsistent with record index");

endmodule
